[rtl/pol_pkg.sv]
// Package for the positional ordered list: sizes, op and status codes,
// and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package pol_pkg;

    // List storage
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // Field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 3;
    localparam int OCNT_W  = 5;

    // Width that holds both a position and count + 1 without wrapping
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Request ops
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 3'd3;
    localparam logic [STAT_W-1:0] ST_DATA   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the request beat
        logic exec;    // carry out the request, load first result
        logic emit;    // load the next entry of a read-all run
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // output register can take a result this cycle
        logic run_more;   // read-all with more than one entry
        logic run_last;   // next run entry is the final one
    } t_stat;

endpackage

`default_nettype wire

[rtl/pol_req_if.sv]
// Request channel: valid/ready handshake with op, position and value.
// Depends on pol_pkg.
`default_nettype none

interface pol_req_if;
    logic                               valid;
    logic                               ready;
    logic        [pol_pkg::OP_W-1:0]    op;
    logic        [pol_pkg::POS_W-1:0]   position;
    logic signed [pol_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

[rtl/pol_rsp_if.sv]
// Result channel: valid/ready handshake with entry data, status, count, last.
// Depends on pol_pkg.
`default_nettype none

interface pol_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [pol_pkg::DATA_W-1:0]  value_out;
    logic        [pol_pkg::STAT_W-1:0]  status;
    logic        [pol_pkg::OCNT_W-1:0]  count_out;
    logic                               last;

    modport source (output valid, output value_out, output status, output count_out,
                    output last, input ready);
    modport sink   (input valid, input value_out, input status, input count_out,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/pol_ctrl.sv]
// Controller for the positional ordered list: request sequencing and
// read-all run stepping. Depends on pol_pkg.
`default_nettype none

module pol_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire pol_pkg::t_stat i_stat,
    output pol_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.run_more ? S_RUN : S_IDLE;
                end
            end
            S_RUN: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.run_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/pol_dp.sv]
// Datapath for the positional ordered list: request latch, shifting entry
// array, entry count, read index and result register. Depends on pol_pkg.
`default_nettype none

module pol_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pol_pkg::t_cmd                      i_cmd,
    output pol_pkg::t_stat                          o_stat,
    input  wire logic        [pol_pkg::OP_W-1:0]    i_op,
    input  wire logic        [pol_pkg::POS_W-1:0]   i_pos,
    input  wire logic signed [pol_pkg::DATA_W-1:0]  i_val,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [pol_pkg::DATA_W-1:0]       o_value,
    output logic        [pol_pkg::STAT_W-1:0]       o_status,
    output logic        [pol_pkg::OCNT_W-1:0]       o_count,
    output logic                                    o_last
);

    localparam int CAP   = pol_pkg::CAPACITY;
    localparam int IDX_W = pol_pkg::IDX_W;
    localparam int CNT_W = pol_pkg::CNT_W;
    localparam int CMP_W = pol_pkg::CMP_W;
    localparam int DW    = pol_pkg::DATA_W;

    // Latched request
    logic [pol_pkg::OP_W-1:0]  r_op;
    logic [pol_pkg::POS_W-1:0] r_pos;
    logic [DW-1:0]             r_val;

    // List state
    logic [DW-1:0]    r_ent [CAP];
    logic [DW-1:0]    n_ent [CAP];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_idx;

    // Result register
    logic                     r_o_valid;
    logic [DW-1:0]            r_o_value;
    logic [pol_pkg::STAT_W-1:0] r_o_status;
    logic [pol_pkg::OCNT_W-1:0] r_o_count;
    logic                     r_o_last;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] kpos_x;
    logic [CMP_W-1:0] cnt_after_x;
    logic [CMP_W-1:0] rd_idx_x;
    logic [CMP_W-1:0] idx_x;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] rd_idx;
    logic             is_read;
    logic             empty;
    logic             full;
    logic             do_ins;
    logic             do_del;
    logic             do_drop;
    logic             rd_entry;
    logic             slot_free;
    logic [pol_pkg::STAT_W-1:0] st;

    assign cnt_x  = CMP_W'(r_cnt);
    assign pos_x  = CMP_W'(r_pos);
    assign kpos_x = pos_x - CMP_W'(1);
    assign empty  = (r_cnt == '0);
    assign full   = (cnt_x >= CMP_W'(CAP));
    assign is_read = (r_op == pol_pkg::OP_READ_ALL);

    // Decode the request against the current count
    always_comb begin
        st      = pol_pkg::ST_DONE;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_drop = 1'b0;
        k       = '0;
        case (r_op)
            pol_pkg::OP_INS_FRONT: begin
                if (full) st = pol_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            pol_pkg::OP_INS_POS: begin
                k = kpos_x[IDX_W-1:0];
                if (full) st = pol_pkg::ST_FULL;
                else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) st = pol_pkg::ST_BADPOS;
                else do_ins = 1'b1;
            end
            pol_pkg::OP_DEL_FRONT: begin
                if (empty) st = pol_pkg::ST_EMPTY;
                else do_del = 1'b1;
            end
            pol_pkg::OP_DEL_POS: begin
                k = kpos_x[IDX_W-1:0];
                if (empty) st = pol_pkg::ST_EMPTY;
                else if (pos_x == '0 || pos_x > cnt_x) st = pol_pkg::ST_BADPOS;
                else do_del = 1'b1;
            end
            pol_pkg::OP_DEL_LAST: begin
                if (empty) st = pol_pkg::ST_EMPTY;
                else do_drop = 1'b1;
            end
            pol_pkg::OP_READ_ALL: begin
                if (empty) st = pol_pkg::ST_EMPTY;
            end
            default: st = pol_pkg::ST_DONE;
        endcase
    end

    // Next count
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.exec) begin
            if (do_ins) n_cnt = r_cnt + CNT_W'(1);
            else if (do_del || do_drop) n_cnt = r_cnt - CNT_W'(1);
        end
    end

    // Per-entry shift: insert moves up from k, delete moves down onto k
    for (genvar g = 0; g < CAP; g++) begin : g_ent
        logic [DW-1:0] w_up;
        logic [DW-1:0] w_dn;
        if (g == 0) begin : g_first
            assign w_up = r_val;
        end else begin : g_rest
            assign w_up = r_ent[g-1];
        end
        if (g == CAP - 1) begin : g_top
            assign w_dn = r_ent[g];
        end else begin : g_below
            assign w_dn = r_ent[g+1];
        end
        always_comb begin
            n_ent[g] = r_ent[g];
            if (i_cmd.exec && do_ins) begin
                if (IDX_W'(g) == k) n_ent[g] = r_val;
                else if (IDX_W'(g) > k) n_ent[g] = w_up;
            end else if (i_cmd.exec && do_del && IDX_W'(g) >= k) begin
                n_ent[g] = w_dn;
            end
        end
    end

    // Read-all source: entry 0 on execute, then the run index
    assign rd_entry    = i_cmd.emit || (i_cmd.exec && is_read && !empty);
    assign rd_idx      = i_cmd.exec ? '0 : r_idx;
    assign rd_idx_x    = CMP_W'(rd_idx);
    assign idx_x       = CMP_W'(r_idx);
    assign cnt_after_x = CMP_W'(n_cnt);
    assign slot_free   = !r_o_valid || i_out_ready;

    assign o_stat.slot_free = slot_free;
    assign o_stat.run_more  = is_read && (cnt_x > CMP_W'(1));
    assign o_stat.run_last  = (idx_x == cnt_x - CMP_W'(1));

    // Request latch and entry array (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_pos <= i_pos;
            r_val <= i_val;
        end
        r_ent <= n_ent;
    end

    // Count and run index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (rd_entry) r_idx <= rd_idx + IDX_W'(1);
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (rd_entry) begin
            r_o_value  <= r_ent[rd_idx];
            r_o_status <= pol_pkg::ST_DATA;
            r_o_count  <= cnt_x[pol_pkg::OCNT_W-1:0];
            r_o_last   <= (rd_idx_x == cnt_x - CMP_W'(1));
        end else if (i_cmd.exec) begin
            r_o_value  <= '0;
            r_o_status <= st;
            r_o_count  <= cnt_after_x[pol_pkg::OCNT_W-1:0];
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_value     = r_o_value;
    assign o_status    = r_o_status;
    assign o_count     = r_o_count;
    assign o_last      = r_o_last;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= CMP_W'(CAP))
        else $error("entry count beyond capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !empty)
        else $error("run step on an empty list");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && i_cmd.emit))
        else $error("execute and run step together");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.emit) |-> slot_free)
        else $error("result loaded over an untaken beat");

endmodule

`default_nettype wire

[rtl/positional_ordered_list_core.sv]
// Positional ordered list: a bounded list of signed 32-bit words held in a
// shifting register array (pol_pkg::CAPACITY entries). Each request beat inserts at the
// front or a 1-based position, deletes the front, a position or the last
// entry, or reads all entries out. Every request yields one result beat with
// a status and last = 1, except a read of a non-empty list, which yields one
// data beat per entry with last on the final one. A request is latched, then
// executed, with a shift of the whole array, once the result register is
// free; a read-all moves one entry per cycle through the single result
// register while the result side does not stall. A new request beat
// is taken once the previous request has loaded its last result, even while
// that result still waits to be taken. No clearing pass after reset.
// Depends on pol_pkg, pol_req_if, pol_rsp_if, pol_ctrl, pol_dp.
`default_nettype none

module positional_ordered_list_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pol_req_if.sink    i_req,
    pol_rsp_if.source  o_rsp
);

    pol_pkg::t_cmd  cmd;
    pol_pkg::t_stat stat;

    // Sequencer
    pol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // List storage and result register
    pol_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_req.op),
        .i_pos       (i_req.position),
        .i_val       (i_req.value),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_value     (o_rsp.value_out),
        .o_status    (o_rsp.status),
        .o_count     (o_rsp.count_out),
        .o_last      (o_rsp.last)
    );

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for positional_ordered_list_core: a directed request table, then
// random request episodes, every result beat checked against an in-bench list predictor.
// Depends on pol_pkg, pol_req_if, pol_rsp_if and the core.

module tb;

    // Field widths taken from the package
    localparam int OP_W   = pol_pkg::OP_W;
    localparam int POS_W  = pol_pkg::POS_W;
    localparam int DATA_W = pol_pkg::DATA_W;
    localparam int STAT_W = pol_pkg::STAT_W;
    localparam int OCNT_W = pol_pkg::OCNT_W;

    // Op codes the core treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RAND_ITEMS   = 330;
    localparam int N_DIRECTED   = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic [STAT_W-1:0] status;
        logic [OCNT_W-1:0] count_out;
        logic              last;
    } t_beat;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
        logic [4:0]        reps;
        logic              typed;
        t_beat             want;
    } t_stim_row;

    typedef enum {EP_FILL, EP_DRAIN, EP_MIXED, EP_NOISE} t_episode;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rsp_ready = 1'b0;

    int snd_idle_pct = 10;
    int rcv_idle_pct = 52;
    int mismatches   = 0;
    int beats_seen   = 0;
    int cycle_count  = 0;

    // Predicted list contents, front first, and result beats still owed
    logic [DATA_W-1:0] list_words [$];
    t_beat             expected_beats [$];
    t_stim_row         directed_rows [N_DIRECTED];

    pol_req_if req_if ();
    pol_rsp_if rsp_if ();

    assign rsp_if.ready = rsp_ready;

    positional_ordered_list_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Compare each taken result beat with the oldest prediction
    always @(posedge clk) begin : result_check
        t_beat want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d unexpected: value %h status %0d count %0d last %0d",
                             beats_seen, rsp_if.value_out, rsp_if.status,
                             rsp_if.count_out, rsp_if.last);
            end else begin
                want = expected_beats.pop_front();
                if (rsp_if.value_out !== want.value_out || rsp_if.status !== want.status ||
                    rsp_if.count_out !== want.count_out || rsp_if.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d mismatch: exp value %h status %0d count %0d",
                                  " last %0d, got value %h status %0d count %0d last %0d"},
                                 beats_seen, want.value_out, want.status, want.count_out,
                                 want.last, rsp_if.value_out, rsp_if.status,
                                 rsp_if.count_out, rsp_if.last);
                end
            end
        end
    end

    // List predictor: apply one request, queue the beats it should produce
    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic [DATA_W-1:0] w);
        t_beat b;
        int    n;
        n = list_words.size();
        b = '{value_out: '0, status: pol_pkg::ST_DONE, count_out: '0, last: 1'b1};
        case (op)
            pol_pkg::OP_INS_FRONT: begin
                if (n >= pol_pkg::CAPACITY) b.status = pol_pkg::ST_FULL;
                else list_words.push_front(w);
            end
            pol_pkg::OP_INS_POS: begin
                if (n >= pol_pkg::CAPACITY) b.status = pol_pkg::ST_FULL;
                else if (pos == 0 || int'(pos) > n + 1) b.status = pol_pkg::ST_BADPOS;
                else list_words.insert(int'(pos) - 1, w);
            end
            pol_pkg::OP_DEL_FRONT: begin
                if (n == 0) b.status = pol_pkg::ST_EMPTY;
                else void'(list_words.pop_front());
            end
            pol_pkg::OP_DEL_POS: begin
                if (n == 0) b.status = pol_pkg::ST_EMPTY;
                else if (pos == 0 || int'(pos) > n) b.status = pol_pkg::ST_BADPOS;
                else list_words.delete(int'(pos) - 1);
            end
            pol_pkg::OP_DEL_LAST: begin
                if (n == 0) b.status = pol_pkg::ST_EMPTY;
                else void'(list_words.pop_back());
            end
            pol_pkg::OP_READ_ALL: begin
                if (n == 0) begin
                    b.status = pol_pkg::ST_EMPTY;
                end else begin
                    // one data beat per entry, last on the final one
                    for (int k = 0; k < n; k++)
                        expected_beats.push_back('{value_out: list_words[k],
                                                   status: pol_pkg::ST_DATA,
                                                   count_out: OCNT_W'(n),
                                                   last: (k == n - 1)});
                    return;
                end
            end
            default: ;
        endcase
        b.count_out = OCNT_W'(list_words.size());
        expected_beats.push_back(b);
    endfunction

    function automatic t_stim_row plain_row(input logic [OP_W-1:0] o,
                                            input logic [POS_W-1:0] p,
                                            input logic [DATA_W-1:0] w,
                                            input logic [4:0] n);
        plain_row          = '0;
        plain_row.op       = o;
        plain_row.position = p;
        plain_row.value    = w;
        plain_row.reps     = n;
    endfunction

    // Single status beat known up front: value 0, last set
    function automatic t_stim_row typed_row(input logic [OP_W-1:0] o,
                                            input logic [POS_W-1:0] p,
                                            input logic [DATA_W-1:0] w,
                                            input logic [STAT_W-1:0] s,
                                            input logic [OCNT_W-1:0] c);
        typed_row                = plain_row(o, p, w, 5'd1);
        typed_row.typed          = 1'b1;
        typed_row.want.status    = s;
        typed_row.want.count_out = c;
        typed_row.want.last      = 1'b1;
    endfunction

    // Drive one request beat, with optional leading idle cycles, and wait for it to go
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] w, input logic typed,
                                input t_beat want);
        if ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= op;
        req_if.position <= pos;
        req_if.value    <= w;
        do @(posedge clk); while (!req_if.ready);
        predict_request(op, pos, w);
        // typed rows take the table's beat in place of the predicted one
        if (typed) expected_beats[expected_beats.size() - 1] = want;
    endtask

    initial begin : stimulus
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] w;
        t_episode          mode;
        int                span;
        int                n;
        int                roll;
        int                ins_lim;
        int                del_lim;
        int                rand_sent;
        int                k;

        req_if.valid    <= 1'b0;
        req_if.op       <= pol_pkg::OP_INS_FRONT;
        req_if.position <= '0;
        req_if.value    <= '0;

        directed_rows = '{
            // empty list: every delete and read underflows
            typed_row(pol_pkg::OP_READ_ALL,  5'd1,  32'h0, pol_pkg::ST_EMPTY, 5'd0),
            typed_row(pol_pkg::OP_DEL_FRONT, 5'd1,  32'h0, pol_pkg::ST_EMPTY, 5'd0),
            typed_row(pol_pkg::OP_DEL_POS,   5'd1,  32'h0, pol_pkg::ST_EMPTY, 5'd0),
            typed_row(pol_pkg::OP_DEL_LAST,  5'd1,  32'h0, pol_pkg::ST_EMPTY, 5'd0),
            // empty list takes position 1 only
            typed_row(pol_pkg::OP_INS_POS,   5'd0,  32'h1, pol_pkg::ST_BADPOS, 5'd0),
            typed_row(pol_pkg::OP_INS_POS,   5'd2,  32'h2, pol_pkg::ST_BADPOS, 5'd0),
            // deleting the only entry empties the list
            typed_row(pol_pkg::OP_INS_FRONT, 5'd1,  32'h8000_0000, pol_pkg::ST_DONE, 5'd1),
            typed_row(pol_pkg::OP_DEL_POS,   5'd1,  32'h0, pol_pkg::ST_DONE, 5'd0),
            typed_row(pol_pkg::OP_READ_ALL,  5'd1,  32'h0, pol_pkg::ST_EMPTY, 5'd0),
            typed_row(pol_pkg::OP_INS_FRONT, 5'd1,  32'h8000_0000, pol_pkg::ST_DONE, 5'd1),
            typed_row(pol_pkg::OP_INS_POS,   5'd2,  32'h7FFF_FFFF, pol_pkg::ST_DONE, 5'd2),
            typed_row(pol_pkg::OP_INS_POS,   5'd31, 32'hFFFF_FFFF, pol_pkg::ST_BADPOS, 5'd2),
            typed_row(OP_SPARE_6,            5'd0,  32'h0, pol_pkg::ST_DONE, 5'd2),
            typed_row(OP_SPARE_7,            5'd31, 32'hFFFF_FFFF, pol_pkg::ST_DONE, 5'd2),
            typed_row(pol_pkg::OP_DEL_POS,   5'd0,  32'h0, pol_pkg::ST_BADPOS, 5'd2),
            typed_row(pol_pkg::OP_DEL_POS,   5'd3,  32'h0, pol_pkg::ST_BADPOS, 5'd2),
            // fill to capacity, then overflow is flagged before the position
            plain_row(pol_pkg::OP_INS_POS,   5'd2,  32'h1234_5678, 5'd14),
            typed_row(pol_pkg::OP_INS_FRONT, 5'd1,  32'h0, pol_pkg::ST_FULL, 5'd16),
            typed_row(pol_pkg::OP_INS_POS,   5'd17, 32'h0, pol_pkg::ST_FULL, 5'd16),
            plain_row(pol_pkg::OP_READ_ALL,  5'd1,  32'h0, 5'd1),
            plain_row(pol_pkg::OP_DEL_POS,   5'd16, 32'h0, 5'd1),
            typed_row(pol_pkg::OP_DEL_POS,   5'd16, 32'h0, pol_pkg::ST_BADPOS, 5'd15),
            plain_row(pol_pkg::OP_DEL_LAST,  5'd1,  32'h0, 5'd1),
            plain_row(pol_pkg::OP_READ_ALL,  5'd1,  32'h0, 5'd1)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r]) begin
            for (k = 0; k < int'(directed_rows[r].reps); k++)
                send_request(directed_rows[r].op, directed_rows[r].position,
                             directed_rows[r].value + DATA_W'(k), directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // Random episodes: mostly well-formed positions, some noise
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2: mode = EP_FILL;
                3, 4, 5: mode = EP_DRAIN;
                9:       mode = EP_NOISE;
                default: mode = EP_MIXED;
            endcase
            case (mode)
                EP_FILL:  begin ins_lim = 70; del_lim = 80; end
                EP_DRAIN: begin ins_lim = 15; del_lim = 85; end
                default:  begin ins_lim = 40; del_lim = 80; end
            endcase
            span = $urandom_range(24, 4);
            repeat (span) begin
                // idle pattern: sender light/receiver heavy, then swapped, then none
                if (rand_sent >= 2 * RAND_ITEMS / 3) begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end else if (rand_sent >= RAND_ITEMS / 3) begin
                    snd_idle_pct = 52;
                    rcv_idle_pct = 10;
                end
                n = list_words.size();
                case ($urandom_range(7))
                    0:       w = 32'h8000_0000;
                    1:       w = 32'h7FFF_FFFF;
                    2:       w = '0;
                    3:       w = '1;
                    default: w = $urandom;
                endcase
                if (mode == EP_NOISE) begin
                    op  = OP_W'($urandom_range(7));
                    pos = POS_W'($urandom_range(31));
                end else begin
                    roll = $urandom_range(99);
                    if (roll < ins_lim) begin
                        op = $urandom_range(1) ? pol_pkg::OP_INS_POS : pol_pkg::OP_INS_FRONT;
                    end else if (roll < del_lim) begin
                        case ($urandom_range(2))
                            0:       op = pol_pkg::OP_DEL_FRONT;
                            1:       op = pol_pkg::OP_DEL_POS;
                            default: op = pol_pkg::OP_DEL_LAST;
                        endcase
                    end else begin
                        op = pol_pkg::OP_READ_ALL;
                    end
                    if ($urandom_range(9) == 0)
                        pos = POS_W'($urandom_range(31));
                    else if (op == pol_pkg::OP_INS_POS)
                        pos = POS_W'($urandom_range(n + 1, 1));
                    else
                        pos = POS_W'($urandom_range((n == 0) ? 1 : n, 1));
                end
                send_request(op, pos, w, 1'b0, '0);
                if (op != OP_SPARE_6 && op != OP_SPARE_7) rand_sent++;
            end
        end

        // Let the last results drain, then allow time for any stray beat
        req_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/pol_pkg.sv
rtl/pol_req_if.sv
rtl/pol_rsp_if.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list_core.sv
dv/tb.sv
